// ----- design/cbm_pkg.sv -----
// Shared types and codes for the bank mapper with scanline interrupt.
package cbm_pkg;

  // Bus event codes carried in the action field
  localparam logic [2:0] ACT_CPU_RD  = 3'd0;
  localparam logic [2:0] ACT_CPU_WR  = 3'd1;
  localparam logic [2:0] ACT_PIC_RD  = 3'd2;
  localparam logic [2:0] ACT_PIC_WR  = 3'd3;
  localparam logic [2:0] ACT_SCAN    = 3'd4;

  // Memory target codes
  localparam logic [1:0] TGT_NONE    = 2'd0;
  localparam logic [1:0] TGT_PRG     = 2'd1;
  localparam logic [1:0] TGT_CHR_ROM = 2'd2;
  localparam logic [1:0] TGT_CHR_RAM = 2'd3;

  // Mirroring codes
  localparam logic [1:0] MIR_VERT    = 2'd0;
  localparam logic [1:0] MIR_HORZ    = 2'd1;
  localparam logic [1:0] MIR_FOUR    = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_PRG_COUNT = 2'd0;
  localparam logic [1:0] CFG_CHR_COUNT = 2'd1;
  localparam logic [1:0] CFG_CHR_RAM   = 2'd2;
  localparam logic [1:0] CFG_MIRROR    = 2'd3;

  localparam int unsigned CfgWidth = 9;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] address;
    logic [7:0]  write_data;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  target;
    logic        mem_write;
    logic [20:0] mem_offset;
    logic [7:0]  mem_data;
    logic        irq_line;
    logic [1:0]  mirroring;
  } out_item_t;

  // Request to the shared remainder unit
  typedef struct packed {
    logic       start;
    logic [7:0] dividend;
    logic [8:0] divisor;
  } mod_req_t;

  // Status back from the remainder unit
  typedef struct packed {
    logic       busy;
    logic       done;
    logic [7:0] remainder;
  } mod_rsp_t;

endpackage

// ----- design/cbm_mod_unit.sv -----
// Bit-serial restoring remainder unit: 8-bit bank number modulo bank count.
module cbm_mod_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cbm_pkg::mod_req_t req_i,
  output cbm_pkg::mod_rsp_t rsp_o
);

  logic       active_q, active_d;
  logic       done_q, done_d;
  logic [2:0] cnt_q, cnt_d;
  logic [7:0] dvd_q, dvd_d;
  logic [8:0] div_q, div_d;
  logic [7:0] rem_q, rem_d;

  logic [8:0] trial;
  logic [8:0] diff;
  logic       fits;

  // One quotient bit per cycle: shift in the next dividend bit, subtract if it fits
  assign trial = {rem_q, dvd_q[7]};
  assign diff  = trial - div_q;
  assign fits  = (trial >= div_q);

  always_comb begin
    active_d = active_q;
    done_d   = 1'b0;
    cnt_d    = cnt_q;
    dvd_d    = dvd_q;
    div_d    = div_q;
    rem_d    = rem_q;
    if (req_i.start) begin
      active_d = 1'b1;
      cnt_d    = 3'd0;
      dvd_d    = req_i.dividend;
      div_d    = req_i.divisor;
      rem_d    = 8'd0;
    end else if (active_q) begin
      rem_d = fits ? diff[7:0] : trial[7:0];
      dvd_d = {dvd_q[6:0], 1'b0};
      cnt_d = cnt_q + 3'd1;
      if (cnt_q == 3'd7) begin
        active_d = 1'b0;
        done_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= 3'd0;
    end else begin
      active_q <= active_d;
      done_q   <= done_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign rsp_o.busy      = active_q;
  assign rsp_o.done      = done_q;
  assign rsp_o.remainder = rem_q;

`ifndef NO_ASSERTIONS
  // A new request never lands on a division in flight
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !active_q)
    else $error("remainder unit restarted while busy");

  // The finished remainder is below the divisor
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> ({1'b0, rem_q} < div_q))
    else $error("remainder not below divisor");
`endif

endmodule

// ----- design/cartridge_bank_mapper_scanline_irq.sv -----
// Top level: bank mapper with scanline interrupt counter, one bus event per item.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one bus event:
//   CPU read or write, picture-bus read or write, or a scanline tick.
//   Output channel (out_valid_o / out_stall_i / out_data_o) returns exactly one
//   item per event: memory target, byte offset, write strobe and data, the
//   interrupt level and the current mirroring.
//   Configuration (cfg_we_i / cfg_idx_i / cfg_wdata_i) sets the bank counts,
//   character RAM select and cartridge mirroring; write it only while idle.
// Sequencing:
//   Program ROM reads of the switchable windows and character ROM reads wrap
//   the bank number through a bit-serial remainder unit that retires one bit
//   per cycle; all other events skip it. One item is computed at a time: a new
//   event is accepted only after the current result leaves the compute state.
// Reset clears all mapper registers and loads the configuration defaults
// (2 program banks, 8 character banks, ROM, vertical). A stalled result holds
// in the output register; the next item still computes, then waits for that
// register, and the input stalls behind it.
module cartridge_bank_mapper_scanline_irq (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  cbm_pkg::in_item_t               in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output cbm_pkg::out_item_t              out_data_o,
  input  logic                            cfg_we_i,
  input  logic [1:0]                      cfg_idx_i,
  input  logic [cbm_pkg::CfgWidth-1:0]    cfg_wdata_i
);

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_CALC = 2'b10
  } state_e;

  // What the latched item still needs
  typedef enum logic [2:0] {
    K_NONE    = 3'd0,
    K_PRG_FIX = 3'd1,
    K_PRG_MOD = 3'd2,
    K_CHR_ROM = 3'd3,
    K_CHR_RAM = 3'd4
  } kind_e;

  // CPU register decode on {address[14:13], address[0]}
  localparam logic [2:0] REG_BANK_SEL = 3'b000;
  localparam logic [2:0] REG_BANK_NUM = 3'b001;
  localparam logic [2:0] REG_MIRROR   = 3'b010;
  localparam logic [2:0] REG_PROTECT  = 3'b011;
  localparam logic [2:0] REG_RELOAD   = 3'b100;
  localparam logic [2:0] REG_REQUEST  = 3'b101;
  localparam logic [2:0] REG_IRQ_OFF  = 3'b110;
  localparam logic [2:0] REG_IRQ_ON   = 3'b111;

  state_e state_q, state_d;

  // Configuration
  logic [8:0] prg_cnt_q, chr_cnt_q;
  logic       chr_ram_q;
  logic [1:0] hdr_mir_q;

  // Mapper state
  logic [7:0] bank_sel_q;
  logic [7:0] bank_num_q [8];
  logic [7:0] irq_reload_q;
  logic [7:0] irq_count_q;
  logic       irq_pending_q;
  logic       irq_enable_q;
  logic       irq_line_q;
  logic       mir_written_q;
  logic       mir_horz_q;

  // Latched item
  kind_e      kind_q, kind_d;
  logic [7:0] bank_q, bank_d;
  logic [12:0] low_q;
  logic       pic_wr_q;
  logic [7:0] wdata_q;

  cbm_pkg::out_item_t out_q, out_d;
  logic       out_valid_q;

  cbm_pkg::mod_req_t mod_req;
  cbm_pkg::mod_rsp_t mod_rsp;

  logic       accept;
  logic       cpu_reg_wr;
  logic [2:0] reg_code;
  logic [8:0] prg_banks, chr_banks;
  logic [7:0] prg_last, prg_last2;
  logic       swap_prg;
  logic [2:0] chr_slot;
  logic [2:0] chr_rest_idx;
  logic [7:0] chr_bank;
  logic [7:0] irq_count_nx;
  logic       scan_reload;
  logic [1:0] mirror_now;
  logic       calc_ready;
  logic       out_free;
  logic       finish;
  logic [7:0] final_bank;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);

  // Clamp counts above 256 to 256
  assign prg_banks = prg_cnt_q[8] ? 9'h100 : prg_cnt_q;
  assign chr_banks = chr_cnt_q[8] ? 9'h100 : chr_cnt_q;
  assign prg_last  = 8'(prg_banks - 9'd1);
  assign prg_last2 = (prg_banks >= 9'd2) ? 8'(prg_banks - 9'd2) : 8'd0;
  assign swap_prg  = bank_sel_q[6];

  // Character window: invert the upper slot bit in the swapped mode
  assign chr_slot     = in_data_i.address[12:10] ^ {bank_sel_q[7], 2'b00};
  assign chr_rest_idx = chr_slot - 3'd2;
  always_comb begin
    if (!chr_slot[2]) begin
      chr_bank = {bank_num_q[{2'b00, chr_slot[1]}][7:1], chr_slot[0]};
    end else begin
      chr_bank = bank_num_q[chr_rest_idx];
    end
  end

  // Issue: classify the event and launch the remainder when a ROM bank is wrapped
  always_comb begin
    kind_d           = K_NONE;
    bank_d           = 8'd0;
    mod_req.start    = 1'b0;
    mod_req.dividend = bank_num_q[6];
    mod_req.divisor  = prg_banks;
    if (accept) begin
      case (in_data_i.action)
        cbm_pkg::ACT_CPU_RD: begin
          if (in_data_i.address[15] && (prg_banks != 9'd0)) begin
            unique case (in_data_i.address[14:13])
              2'd0: begin
                if (swap_prg) begin
                  kind_d = K_PRG_FIX;
                  bank_d = prg_last2;
                end else begin
                  kind_d = K_PRG_MOD;
                end
              end
              2'd1: begin
                kind_d           = K_PRG_MOD;
                mod_req.dividend = bank_num_q[7];
              end
              2'd2: begin
                if (swap_prg) begin
                  kind_d = K_PRG_MOD;
                end else begin
                  kind_d = K_PRG_FIX;
                  bank_d = prg_last2;
                end
              end
              default: begin
                kind_d = K_PRG_FIX;
                bank_d = prg_last;
              end
            endcase
            mod_req.start = (kind_d == K_PRG_MOD);
          end
        end
        cbm_pkg::ACT_PIC_RD, cbm_pkg::ACT_PIC_WR: begin
          if (chr_ram_q) begin
            kind_d = K_CHR_RAM;
            bank_d = chr_bank;
          end else if ((in_data_i.action == cbm_pkg::ACT_PIC_RD) &&
                       (chr_banks != 9'd0)) begin
            kind_d           = K_CHR_ROM;
            mod_req.start    = 1'b1;
            mod_req.dividend = chr_bank;
            mod_req.divisor  = chr_banks;
          end
        end
        default: begin
          kind_d = K_NONE;
        end
      endcase
    end
  end

  cbm_mod_unit u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .rsp_o  (mod_rsp)
  );

  // CPU register writes and scanline counter
  assign cpu_reg_wr = accept && (in_data_i.action == cbm_pkg::ACT_CPU_WR) &&
                      in_data_i.address[15];
  assign reg_code   = {in_data_i.address[14:13], in_data_i.address[0]};
  assign scan_reload  = (irq_count_q == 8'd0) || irq_pending_q;
  assign irq_count_nx = scan_reload ? irq_reload_q : (irq_count_q - 8'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prg_cnt_q     <= 9'd2;
      chr_cnt_q     <= 9'd8;
      chr_ram_q     <= 1'b0;
      hdr_mir_q     <= cbm_pkg::MIR_VERT;
      bank_sel_q    <= 8'd0;
      for (int i = 0; i < 8; i++) begin
        bank_num_q[i] <= 8'd0;
      end
      irq_reload_q  <= 8'd0;
      irq_count_q   <= 8'd0;
      irq_pending_q <= 1'b0;
      irq_enable_q  <= 1'b0;
      irq_line_q    <= 1'b0;
      mir_written_q <= 1'b0;
      mir_horz_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          cbm_pkg::CFG_PRG_COUNT: prg_cnt_q <= cfg_wdata_i;
          cbm_pkg::CFG_CHR_COUNT: chr_cnt_q <= cfg_wdata_i;
          cbm_pkg::CFG_CHR_RAM:   chr_ram_q <= cfg_wdata_i[0];
          default:                hdr_mir_q <= cfg_wdata_i[1:0];
        endcase
      end
      if (cpu_reg_wr) begin
        unique case (reg_code)
          REG_BANK_SEL: bank_sel_q <= in_data_i.write_data;
          REG_BANK_NUM: bank_num_q[bank_sel_q[2:0]] <= in_data_i.write_data;
          REG_MIRROR: begin
            if (hdr_mir_q != cbm_pkg::MIR_FOUR) begin
              mir_written_q <= 1'b1;
              mir_horz_q    <= in_data_i.write_data[0];
            end
          end
          REG_PROTECT: ;
          REG_RELOAD:  irq_reload_q  <= in_data_i.write_data;
          REG_REQUEST: irq_pending_q <= 1'b1;
          REG_IRQ_OFF: begin
            irq_enable_q <= 1'b0;
            irq_line_q   <= 1'b0;
          end
          default:     irq_enable_q <= 1'b1;
        endcase
      end
      if (accept && (in_data_i.action == cbm_pkg::ACT_SCAN)) begin
        irq_count_q <= irq_count_nx;
        if (scan_reload) begin
          irq_pending_q <= 1'b0;
        end
        if ((irq_count_nx == 8'd0) && irq_enable_q) begin
          irq_line_q <= 1'b1;
        end
      end
    end
  end

  // Latch the item for the result stage
  always_ff @(posedge clk_i) begin
    if (accept) begin
      bank_q   <= bank_d;
      low_q    <= in_data_i.address[12:0];
      pic_wr_q <= (in_data_i.action == cbm_pkg::ACT_PIC_WR);
      wdata_q  <= in_data_i.write_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= K_NONE;
    end else if (accept) begin
      kind_q <= kind_d;
    end
  end

  // Current mirroring
  always_comb begin
    if (hdr_mir_q == cbm_pkg::MIR_FOUR) begin
      mirror_now = cbm_pkg::MIR_FOUR;
    end else if (mir_written_q) begin
      mirror_now = mir_horz_q ? cbm_pkg::MIR_HORZ : cbm_pkg::MIR_VERT;
    end else begin
      mirror_now = (hdr_mir_q == cbm_pkg::MIR_HORZ) ? cbm_pkg::MIR_HORZ
                                                   : cbm_pkg::MIR_VERT;
    end
  end

  // Compose the result: wrapped bank from the remainder unit or the latched bank
  assign final_bank = ((kind_q == K_PRG_MOD) || (kind_q == K_CHR_ROM)) ?
                      mod_rsp.remainder : bank_q;

  always_comb begin
    out_d            = '0;
    out_d.target     = cbm_pkg::TGT_NONE;
    out_d.irq_line   = irq_line_q;
    out_d.mirroring  = mirror_now;
    case (kind_q)
      K_PRG_FIX, K_PRG_MOD: begin
        out_d.target     = cbm_pkg::TGT_PRG;
        out_d.mem_offset = {final_bank, low_q};
      end
      K_CHR_ROM: begin
        out_d.target     = cbm_pkg::TGT_CHR_ROM;
        out_d.mem_offset = {3'd0, final_bank, low_q[9:0]};
      end
      K_CHR_RAM: begin
        out_d.target     = cbm_pkg::TGT_CHR_RAM;
        out_d.mem_offset = {8'd0, final_bank[2:0], low_q[9:0]};
        out_d.mem_write  = pic_wr_q;
        out_d.mem_data   = pic_wr_q ? wdata_q : 8'd0;
      end
      default: begin
        out_d.target = cbm_pkg::TGT_NONE;
      end
    endcase
  end

  // Leave the compute state once any needed remainder is ready and the
  // output register is empty or being taken this cycle
  assign calc_ready = ((kind_q != K_PRG_MOD) && (kind_q != K_CHR_ROM)) || !mod_rsp.busy;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign finish     = (state_q == ST_CALC) && calc_ready && out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept) state_d = ST_CALC;
      ST_CALC: if (finish) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  // The remainder unit only finishes while a result is being built
  a_done_in_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_rsp.done |-> (state_q == ST_CALC))
    else $error("remainder finished outside compute state");

  // Interrupt rises only after an accepted scanline tick
  a_irq_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(irq_line_q) |-> $past(accept && (in_data_i.action == cbm_pkg::ACT_SCAN)))
    else $error("interrupt raised without scanline");

  // No memory target means zero offset and no write
  a_none_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.target == cbm_pkg::TGT_NONE)) |->
      ((out_data_o.mem_offset == 21'd0) && !out_data_o.mem_write))
    else $error("idle target carries an access");
`endif

endmodule
